>>> rtl/core/clp_pkg.sv
// Shared types, character codes and digit decode for the integer literal parser.
`timescale 1ns / 1ps
package clp_pkg;

  // APB register map
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [0:0]  REG_LONG_IS_WIDE = 1'b0;

  // ASCII codes
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LL    = 8'h6C;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Suffix patterns, oldest character in the top byte
  localparam logic [23:0] SFX_ULL_U = "ULL";
  localparam logic [23:0] SFX_ULL_L = "ull";
  localparam logic [23:0] SFX_LLU_U = "LLU";
  localparam logic [23:0] SFX_LLU_L = "llu";
  localparam logic [15:0] SFX_UL_U  = "UL";
  localparam logic [15:0] SFX_UL_L  = "ul";
  localparam logic [15:0] SFX_LL_U  = "LL";
  localparam logic [15:0] SFX_LL_L  = "ll";
  localparam logic [15:0] SFX_UU_U  = "UU";
  localparam logic [15:0] SFX_UU_L  = "uu";

  localparam logic [4:0] RADIX_BIN = 5'd2;
  localparam logic [4:0] RADIX_OCT = 5'd8;
  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [4:0] RADIX_HEX = 5'd16;
  localparam logic [4:0] DIGIT_BAD = 5'd31;

  localparam int unsigned DSUM_W = 12;

  localparam logic [63:0] MASK_CHAR = 64'h0000_0000_0000_00FF;
  localparam logic [63:0] MASK_32   = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [6:0] {
    PH_START = 7'b0000001,
    PH_SIGN  = 7'b0000010,
    PH_ZERO  = 7'b0000100,
    PH_BODY  = 7'b0001000,
    PH_QUOTE = 7'b0010000,
    PH_CHARV = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_e;

  typedef enum logic [2:0] {
    TY_INT    = 3'd0,
    TY_UINT   = 3'd1,
    TY_LONG   = 3'd2,
    TY_ULONG  = 3'd3,
    TY_LLONG  = 3'd4,
    TY_ULLONG = 3'd5,
    TY_CHAR   = 3'd6
  } type_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_CHAR = 2'd1,
    ERR_UU   = 2'd2,
    ERR_SIGN = 2'd3
  } err_e;

  // Literal state at its final character
  typedef struct packed {
    logic [23:0] window;
    logic [1:0]  count;
    logic [4:0]  radix;
    logic        negative;
    logic        sign_err;
    logic        charv;
    err_e        err;
  } snap_t;

  // Decoded literal, ready for the final scale-add
  typedef struct packed {
    type_e             ty;
    err_e              err;
    logic              negative;
    logic [4:0]        radix;
    logic [1:0]        ndig;
    logic [DSUM_W-1:0] dsum;
  } fin_t;

  // Hex digit value, DIGIT_BAD for anything else
  function automatic logic [4:0] digit_of(logic [7:0] c);
    logic [7:0] l;
    logic [4:0] d;
    l = c | CASE_BIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 5'(c - CH_ZERO);
    end else if (l >= CH_LA && l <= CH_LF) begin
      d = 5'(l - CH_LA) + 5'd10;
    end else begin
      d = DIGIT_BAD;
    end
    return d;
  endfunction

endpackage

>>> rtl/core/clp_if.sv
// Valid/ready channel interfaces for characters in and parse results out.
`timescale 1ns / 1ps
interface clp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface clp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [2:0]  type_code;
  logic [1:0]  error_code;

  modport source (output valid, output value, output type_code, output error_code,
                  input ready);
  modport sink   (input valid, input value, input type_code, input error_code,
                  output ready);
endinterface

>>> rtl/core/clp_regs.sv
// APB configuration register block.
`timescale 1ns / 1ps
module clp_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [clp_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [clp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [clp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic                             long_is_wide_o
);
  import clp_pkg::*;

  logic long_is_wide_q;
  logic reg_sel;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_LONG_IS_WIDE);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_is_wide_q <= 1'b0;
    end else if (wr_en) begin
      long_is_wide_q <= pwdata[0];
    end
  end

  assign prdata         = reg_sel ? {{(APB_DATA_W-1){1'b0}}, long_is_wide_q} : '0;
  assign long_is_wide_o = long_is_wide_q;

endmodule

>>> rtl/core/clp_scan.sv
// Per-character literal state: sign, radix prefix, suffix window and accumulator.
`timescale 1ns / 1ps
module clp_scan #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  clp_in_if.sink                in_i,
  input  logic                  snap_ready_i,
  output logic                  snap_valid_o,
  output clp_pkg::snap_t        snap_o,
  output logic [VALUE_BITS-1:0] snap_accum_o
);
  import clp_pkg::*;

  phase_e                phase_q, phase_d;
  logic [4:0]            radix_q, radix_d;
  logic [VALUE_BITS-1:0] accum_q, accum_d;
  logic                  negative_q, negative_d;
  logic [23:0]           window_q, window_d;
  logic [1:0]            count_q, count_d;
  logic [2:0]            pos_q, pos_d;
  err_e                  err_q, err_d;

  logic                  snap_valid_q;
  snap_t                 snap_q;
  logic [VALUE_BITS-1:0] snap_accum_q;

  logic                  accept;
  logic                  push;
  logic [7:0]            ch;
  logic [4:0]            ch_dig;
  logic [4:0]            old_dig;
  logic [VALUE_BITS-1:0] scaled;

  assign ch        = in_i.ch;
  assign in_i.ready = !snap_valid_q || snap_ready_i;
  assign accept    = in_i.valid && in_i.ready;
  assign ch_dig    = digit_of(ch);
  assign old_dig   = digit_of(window_q[23:16]);

  always_comb begin
    case (radix_q)
      RADIX_HEX: scaled = accum_q << 4;
      RADIX_OCT: scaled = accum_q << 3;
      RADIX_BIN: scaled = accum_q << 1;
      default:   scaled = (accum_q << 3) + (accum_q << 1);
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    radix_d    = radix_q;
    accum_d    = accum_q;
    negative_d = negative_q;
    window_d   = window_q;
    count_d    = count_q;
    err_d      = err_q;
    push       = 1'b0;

    case (phase_q)
      PH_START: begin
        if (ch == CH_QUOTE) begin
          push    = 1'b1;
          phase_d = PH_QUOTE;
        end else if (ch == CH_MINUS) begin
          negative_d = 1'b1;
          phase_d    = PH_SIGN;
        end else if (ch == CH_PLUS) begin
          phase_d = PH_SIGN;
        end else if (ch == CH_ZERO) begin
          phase_d = PH_ZERO;
        end else begin
          push    = 1'b1;
          phase_d = PH_BODY;
        end
      end
      PH_SIGN: begin
        if (ch_dig >= RADIX_HEX) begin
          err_d   = ERR_SIGN;
          phase_d = PH_DONE;
        end else if (ch == CH_ZERO) begin
          phase_d = PH_ZERO;
        end else begin
          push    = 1'b1;
          phase_d = PH_BODY;
        end
      end
      PH_ZERO: begin
        if ((ch | CASE_BIT) == CH_LX) begin
          radix_d = RADIX_HEX;
        end else if ((ch | CASE_BIT) == CH_LB) begin
          radix_d = RADIX_BIN;
        end else begin
          radix_d = RADIX_OCT;
          push    = 1'b1;
        end
        phase_d = PH_BODY;
      end
      PH_BODY: begin
        push = 1'b1;
      end
      PH_QUOTE: begin
        push = 1'b1;
      end
      default: begin
      end
    endcase

    // full window: the oldest character drops out into the body
    if (push && count_q == 2'd3) begin
      if (old_dig >= radix_q) begin
        if (err_d == ERR_NONE) begin
          err_d = ERR_CHAR;
        end
      end else begin
        accum_d = scaled + VALUE_BITS'(old_dig);
      end
    end
    if (push) begin
      window_d = {window_q[15:0], ch};
      if (count_q != 2'd3) begin
        count_d = count_q + 2'd1;
      end
    end

    // closing quote of the 'c' form
    if (phase_q == PH_QUOTE && pos_q == 3'd2) begin
      if (ch == CH_QUOTE) begin
        accum_d = VALUE_BITS'(window_q[7:0]);
        phase_d = PH_CHARV;
      end else begin
        phase_d = PH_BODY;
      end
    end
  end

  assign pos_d = (pos_q != 3'd7) ? pos_q + 3'd1 : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      radix_q      <= RADIX_DEC;
      accum_q      <= '0;
      negative_q   <= 1'b0;
      window_q     <= '0;
      count_q      <= '0;
      pos_q        <= '0;
      err_q        <= ERR_NONE;
      snap_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (in_i.last) begin
          phase_q    <= PH_START;
          radix_q    <= RADIX_DEC;
          accum_q    <= '0;
          negative_q <= 1'b0;
          window_q   <= '0;
          count_q    <= '0;
          pos_q      <= '0;
          err_q      <= ERR_NONE;
        end else begin
          phase_q    <= phase_d;
          radix_q    <= radix_d;
          accum_q    <= accum_d;
          negative_q <= negative_d;
          window_q   <= window_d;
          count_q    <= count_d;
          pos_q      <= pos_d;
          err_q      <= err_d;
        end
      end
      if (accept && in_i.last) begin
        snap_valid_q <= 1'b1;
      end else if (snap_ready_i) begin
        snap_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.last) begin
      snap_q.window   <= window_d;
      snap_q.count    <= count_d;
      snap_q.radix    <= radix_d;
      snap_q.negative <= negative_d;
      snap_q.sign_err <= (phase_d == PH_SIGN) || (err_d == ERR_SIGN);
      snap_q.charv    <= (phase_d == PH_CHARV);
      snap_q.err      <= err_d;
      snap_accum_q    <= accum_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;
  assign snap_accum_o = snap_accum_q;

endmodule

>>> rtl/core/clp_suffix.sv
// Suffix decode, leftover body digits and error priority.
`timescale 1ns / 1ps
module clp_suffix #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  snap_valid_i,
  output logic                  snap_ready_o,
  input  clp_pkg::snap_t        snap_i,
  input  logic [VALUE_BITS-1:0] snap_accum_i,
  output logic                  fin_valid_o,
  input  logic                  fin_ready_i,
  output clp_pkg::fin_t         fin_o,
  output logic [VALUE_BITS-1:0] fin_accum_o
);
  import clp_pkg::*;

  logic                  fin_valid_q;
  fin_t                  fin_q, fin_d;
  logic [VALUE_BITS-1:0] fin_accum_q;

  logic [23:0]       w;
  logic [1:0]        cnt;
  logic [4:0]        r;
  logic [9:0]        r2;
  logic              m_ull, m_ul, m_ll, m_uu, m_l, m_u;
  logic [1:0]        k;
  logic [1:0]        n;
  type_e             sfx_ty;
  logic              uu;
  logic [4:0]        dig0, dig1, dig2;
  logic              use0, use1, use2;
  logic              digit_err;
  logic [DSUM_W-1:0] dsum;

  function automatic logic [7:0] byte_at(logic [23:0] win, logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = win[7:0];
      2'd1:    b = win[15:8];
      2'd2:    b = win[23:16];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  assign w   = snap_i.window;
  assign cnt = snap_i.count;
  assign r   = snap_i.radix;

  assign m_ull = (cnt == 2'd3) &&
                 (w == SFX_ULL_U || w == SFX_ULL_L || w == SFX_LLU_U || w == SFX_LLU_L);
  assign m_ul  = (cnt >= 2'd2) && (w[15:0] == SFX_UL_U || w[15:0] == SFX_UL_L);
  assign m_ll  = (cnt >= 2'd2) && (w[15:0] == SFX_LL_U || w[15:0] == SFX_LL_L);
  assign m_uu  = (cnt >= 2'd2) && (w[15:0] == SFX_UU_U || w[15:0] == SFX_UU_L);
  assign m_l   = (cnt != 2'd0) && ((w[7:0] | CASE_BIT) == CH_LL);
  assign m_u   = (cnt != 2'd0) && ((w[7:0] | CASE_BIT) == CH_LU);

  always_comb begin
    k      = 2'd0;
    sfx_ty = TY_INT;
    uu     = 1'b0;
    if (m_ull) begin
      k      = 2'd3;
      sfx_ty = TY_ULLONG;
    end else if (m_ul) begin
      k      = 2'd2;
      sfx_ty = TY_ULONG;
    end else if (m_ll) begin
      k      = 2'd2;
      sfx_ty = TY_LLONG;
    end else if (m_uu) begin
      uu = 1'b1;
    end else if (m_l) begin
      k      = 2'd1;
      sfx_ty = TY_LONG;
    end else if (m_u) begin
      k      = 2'd1;
      sfx_ty = TY_UINT;
    end
  end

  // characters below the suffix are body digits, newest is least significant
  assign n    = cnt - k;
  assign use0 = (n > 2'd0);
  assign use1 = (n > 2'd1);
  assign use2 = (n > 2'd2);
  assign dig0 = digit_of(byte_at(w, k));
  assign dig1 = digit_of(byte_at(w, k + 2'd1));
  assign dig2 = digit_of(byte_at(w, k + 2'd2));

  assign digit_err = (use0 && dig0 >= r) || (use1 && dig1 >= r) || (use2 && dig2 >= r);

  assign r2 = 10'(r) * 10'(r);

  assign dsum = (use0 ? DSUM_W'(dig0) : '0)
              + (use1 ? DSUM_W'(dig1) * DSUM_W'(r) : '0)
              + (use2 ? DSUM_W'(dig2) * DSUM_W'(r2) : '0);

  always_comb begin
    fin_d.negative = snap_i.negative;
    fin_d.radix    = r;
    fin_d.ndig     = n;
    fin_d.dsum     = dsum;
    fin_d.ty       = TY_INT;
    fin_d.err      = ERR_NONE;
    if (snap_i.sign_err) begin
      fin_d.err = ERR_SIGN;
    end else if (snap_i.charv) begin
      fin_d.ty   = TY_CHAR;
      fin_d.ndig = 2'd0;
      fin_d.dsum = '0;
    end else if (uu) begin
      fin_d.err = ERR_UU;
    end else if (snap_i.err != ERR_NONE || digit_err) begin
      fin_d.err = ERR_CHAR;
    end else begin
      fin_d.ty = sfx_ty;
    end
  end

  assign snap_ready_o = !fin_valid_q || fin_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (snap_ready_o) begin
      fin_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_ready_o && snap_valid_i) begin
      fin_q       <= fin_d;
      fin_accum_q <= snap_accum_i;
    end
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_o       = fin_q;
  assign fin_accum_o = fin_accum_q;

endmodule

>>> rtl/core/clp_finish.sv
// Final multiply-add, negation, type-size mask and result register.
`timescale 1ns / 1ps
module clp_finish #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fin_valid_i,
  output logic                  fin_ready_o,
  input  clp_pkg::fin_t         fin_i,
  input  logic [VALUE_BITS-1:0] fin_accum_i,
  input  logic                  long_is_wide_i,
  clp_out_if.source             out_o
);
  import clp_pkg::*;

  logic                  mid_valid_q;
  logic [VALUE_BITS-1:0] mid_value_q;
  type_e                 mid_ty_q;
  err_e                  mid_err_q;
  logic                  mid_neg_q;

  logic                  out_valid_q;
  logic [63:0]           out_value_q;
  type_e                 out_ty_q;
  err_e                  out_err_q;

  logic                  out_adv;
  logic                  mid_ready;
  logic [3:0]            oct_shift;
  logic [VALUE_BITS-1:0] scaled;
  logic [VALUE_BITS-1:0] prod;
  logic [VALUE_BITS-1:0] signed_val;
  logic [63:0]           mask;
  logic                  is_wide;
  logic [63:0]           value_d;

  assign out_adv     = !out_valid_q || out_o.ready;
  assign mid_ready   = !mid_valid_q || out_adv;
  assign fin_ready_o = mid_ready;

  // accumulator times radix^ndig: shifts for powers of two, shift-add or shift-subtract for ten
  assign oct_shift = {1'b0, fin_i.ndig, 1'b0} + {2'b00, fin_i.ndig};

  always_comb begin
    case (fin_i.radix)
      RADIX_HEX: scaled = fin_accum_i << {fin_i.ndig, 2'b00};
      RADIX_OCT: scaled = fin_accum_i << oct_shift;
      RADIX_BIN: scaled = fin_accum_i << fin_i.ndig;
      default: begin
        case (fin_i.ndig)
          2'd0:    scaled = fin_accum_i;
          2'd1:    scaled = (fin_accum_i << 3) + (fin_accum_i << 1);
          2'd2:    scaled = (fin_accum_i << 6) + (fin_accum_i << 5) + (fin_accum_i << 2);
          default: scaled = (fin_accum_i << 10) - (fin_accum_i << 4) - (fin_accum_i << 3);
        endcase
      end
    endcase
  end

  assign prod = scaled + VALUE_BITS'(fin_i.dsum);

  assign signed_val = mid_neg_q ? (~mid_value_q + VALUE_BITS'(1)) : mid_value_q;
  assign is_wide    = (mid_ty_q == TY_LLONG) || (mid_ty_q == TY_ULLONG) ||
                      (long_is_wide_i && (mid_ty_q == TY_LONG || mid_ty_q == TY_ULONG));

  always_comb begin
    if (mid_ty_q == TY_CHAR) begin
      mask = MASK_CHAR;
    end else if (is_wide) begin
      mask = '1;
    end else begin
      mask = MASK_32;
    end
  end

  assign value_d = (mid_err_q == ERR_NONE) ? (64'(signed_val) & mask) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mid_ready) begin
        mid_valid_q <= fin_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= mid_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_ready && fin_valid_i) begin
      mid_value_q <= prod;
      mid_ty_q    <= fin_i.ty;
      mid_err_q   <= fin_i.err;
      mid_neg_q   <= fin_i.negative;
    end
    if (out_adv && mid_valid_q) begin
      out_value_q <= value_d;
      out_ty_q    <= (mid_err_q == ERR_NONE) ? mid_ty_q : TY_INT;
      out_err_q   <= mid_err_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.value      = out_value_q;
  assign out_o.type_code  = out_ty_q;
  assign out_o.error_code = out_err_q;

endmodule

>>> rtl/core/c_integer_literal_parser_unit.sv
// C integer literal parser: one character per transaction, one result per literal.
// Throughput: one character per cycle while the snapshot register is not stalled.
// Result path: the last character's snapshot register, then suffix decode, final
//   multiply-add, then negate and mask into the output register.
// Reset (rst_ni, async, active low): literal state and pipeline cleared, long_is_wide = 0.
`timescale 1ns / 1ps
module c_integer_literal_parser_unit #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [clp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [clp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [clp_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  clp_in_if.sink                         in_i,
  clp_out_if.source                      out_o
);
  import clp_pkg::*;

  logic                  long_is_wide;
  logic                  snap_valid;
  logic                  snap_ready;
  snap_t                 snap;
  logic [VALUE_BITS-1:0] snap_accum;
  logic                  fin_valid;
  logic                  fin_ready;
  fin_t                  fin;
  logic [VALUE_BITS-1:0] fin_accum;

  clp_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .long_is_wide_o (long_is_wide)
  );

  clp_scan #(.VALUE_BITS(VALUE_BITS)) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .snap_ready_i (snap_ready),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_accum_o (snap_accum)
  );

  clp_suffix #(.VALUE_BITS(VALUE_BITS)) u_suffix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .snap_accum_i (snap_accum),
    .fin_valid_o  (fin_valid),
    .fin_ready_i  (fin_ready),
    .fin_o        (fin),
    .fin_accum_o  (fin_accum)
  );

  clp_finish #(.VALUE_BITS(VALUE_BITS)) u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fin_valid_i    (fin_valid),
    .fin_ready_o    (fin_ready),
    .fin_i          (fin),
    .fin_accum_i    (fin_accum),
    .long_is_wide_i (long_is_wide),
    .out_o          (out_o)
  );

endmodule

>>> rtl/core/clp_checker.sv
// Port-level assertions for the literal parser, bound to the top level.
`timescale 1ns / 1ps
module clp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_value_i,
  input logic [2:0]  out_type_i,
  input logic [1:0]  out_err_i
);
  import clp_pkg::*;

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) &&
                                    $stable(out_type_i) && $stable(out_err_i))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_err_i != ERR_NONE |-> out_value_i == 64'd0 && out_type_i == TY_INT)
    else $error("error result carries value or type");

  a_char_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_type_i == TY_CHAR |-> out_value_i[63:8] == 56'd0)
    else $error("char value wider than a byte");

  a_int_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_type_i == TY_INT || out_type_i == TY_UINT)
      |-> out_value_i[63:32] == 32'd0)
    else $error("int value wider than 32 bits");

endmodule

bind c_integer_literal_parser_unit clp_checker u_clp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value),
  .out_type_i  (out_o.type_code),
  .out_err_i   (out_o.error_code)
);
